### hw/rtl/hyp_pkg.sv
`default_nettype none
package hyp_pkg;

  localparam logic [31:0] INF_BITS  = 32'h7f80_0000;
  localparam logic [31:0] ABS_MASK  = 32'h7fff_ffff;
  localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

  // root unit: 32 result bits, two per stage
  localparam int SQ_STAGES = 16;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_TOP    = 62;

  // special result decided at the input (infinity, NaN, both zero)
  typedef struct packed {
    logic        hit;
    logic [31:0] bits;
  } spec_t;

  // one operand, normalized: value = m * 2^e, m[23] set unless zero
  typedef struct packed {
    logic               zero;
    logic [23:0]        m;
    logic signed [11:0] e;
  } unp_t;

  // exact squares, normalized: value = p * 2^e, p[47] set unless zero
  typedef struct packed {
    spec_t              spec;
    logic               xz;
    logic               yz;
    logic [47:0]        xp;
    logic [47:0]        yp;
    logic signed [11:0] xe;
    logic signed [11:0] ye;
  } sq_t;

  // aligned addends; elsb is the exponent of bit 0
  typedef struct packed {
    spec_t              spec;
    logic [111:0]       big;
    logic [111:0]       lesser;
    logic               sticky;
    logic signed [11:0] elsb;
  } aln_t;

  // double-rounded sum: value = m * 2^e, m[52] set
  typedef struct packed {
    spec_t              spec;
    logic [52:0]        m;
    logic signed [11:0] e;
  } sum_t;

  // running state of the digit-by-digit root
  typedef struct packed {
    spec_t              spec;
    logic [62:0]        rem;
    logic [63:0]        res;
    logic               odd;
    logic signed [11:0] h;
  } root_t;

endpackage
`default_nettype wire

### hw/rtl/hyp_front.sv
`default_nettype none
module hyp_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         vld_i,
  input  wire logic [31:0]  x_bits_i,
  input  wire logic [31:0]  y_bits_i,
  output logic              vld_o,
  output hyp_pkg::sq_t      sq_o
);
  import hyp_pkg::*;

  function automatic unp_t unpack(input logic [31:0] b);
    unp_t        u;
    logic [23:0] m24;
    logic [4:0]  lz;
    logic        found;
    u.zero = (b[30:0] == 31'd0);
    m24    = {1'b0, b[22:0]};
    lz     = '0;
    found  = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m24[i]) begin
        lz    = 5'(23 - i);
        found = 1'b1;
      end
    end
    if (b[30:23] != 8'd0) begin
      u.m = {1'b1, b[22:0]};
      u.e = $signed({4'b0, b[30:23]}) - 12'sd150;
    end else begin
      u.m = m24 << lz;
      u.e = -12'sd149 - $signed({7'b0, lz});
    end
    return u;
  endfunction

  logic [31:0] xa, ya;
  spec_t       spec_d, spec_q;
  unp_t        x_q, y_q;
  logic        vld1_q, vld2_q;
  logic [47:0] xp, yp;
  sq_t         sq_d, sq_q;

  assign xa = x_bits_i & ABS_MASK;
  assign ya = y_bits_i & ABS_MASK;

  always_comb begin
    spec_d.hit  = 1'b1;
    spec_d.bits = '0;
    if (xa == INF_BITS || ya == INF_BITS) begin
      spec_d.bits = INF_BITS;
    end else if (xa > INF_BITS) begin
      spec_d.bits = x_bits_i | QUIET_BIT;
    end else if (ya > INF_BITS) begin
      spec_d.bits = y_bits_i | QUIET_BIT;
    end else if (xa == 32'd0 && ya == 32'd0) begin
      spec_d.bits = '0;
    end else begin
      spec_d.hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      spec_q <= spec_d;
      x_q    <= unpack(x_bits_i);
      y_q    <= unpack(y_bits_i);
      sq_q   <= sq_d;
    end
  end

  assign xp = x_q.m * x_q.m;
  assign yp = y_q.m * y_q.m;

  always_comb begin
    sq_d.spec = spec_q;
    sq_d.xz   = x_q.zero;
    sq_d.yz   = y_q.zero;
    if (xp[47]) begin
      sq_d.xp = xp;
      sq_d.xe = {x_q.e[10:0], 1'b0};
    end else begin
      sq_d.xp = {xp[46:0], 1'b0};
      sq_d.xe = {x_q.e[10:0], 1'b0} - 12'sd1;
    end
    if (yp[47]) begin
      sq_d.yp = yp;
      sq_d.ye = {y_q.e[10:0], 1'b0};
    end else begin
      sq_d.yp = {yp[46:0], 1'b0};
      sq_d.ye = {y_q.e[10:0], 1'b0} - 12'sd1;
    end
  end

  assign vld_o = vld2_q;
  assign sq_o  = sq_q;

endmodule
`default_nettype wire

### hw/rtl/hyp_add.sv
`default_nettype none
module hyp_add (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire hyp_pkg::sq_t  sq_i,
  output logic               vld_o,
  output hyp_pkg::sum_t      sum_o
);
  import hyp_pkg::*;

  aln_t         aln_d, aln_q;
  sum_t         sum_d, sum_q;
  logic         vld1_q, vld2_q;
  logic [47:0]  pb, ps;
  logic signed [11:0] eb, es;
  logic [11:0]  sh_amt;
  logic [111:0] sw, mask;
  logic [112:0] s;
  logic [52:0]  k;
  logic [53:0]  kr;
  logic         g, st;
  logic signed [11:0] ek;

  // pick the larger square, shift the other one right
  always_comb begin
    if (sq_i.xz || (!sq_i.yz && sq_i.ye > sq_i.xe)) begin
      pb = sq_i.yp; eb = sq_i.ye;
      ps = sq_i.xz ? 48'd0 : sq_i.xp; es = sq_i.xe;
    end else begin
      pb = sq_i.xp; eb = sq_i.xe;
      ps = sq_i.yz ? 48'd0 : sq_i.yp; es = sq_i.ye;
    end
    sh_amt = 12'(eb - es);
    sw     = {ps, 64'd0};
    mask   = ~({112{1'b1}} << sh_amt[6:0]);
    aln_d.spec = sq_i.spec;
    aln_d.big  = {pb, 64'd0};
    aln_d.elsb = eb - 12'sd64;
    if (ps == 48'd0) begin
      aln_d.lesser = '0;
      aln_d.sticky = 1'b0;
    end else if (sh_amt >= 12'd112) begin
      aln_d.lesser = '0;
      aln_d.sticky = 1'b1;
    end else begin
      aln_d.lesser = sw >> sh_amt[6:0];
      aln_d.sticky = |(sw & mask);
    end
  end

  // add and round to 53 bits, nearest even
  always_comb begin
    s = {1'b0, aln_q.big} + {1'b0, aln_q.lesser};
    if (s[112]) begin
      k  = s[112:60];
      g  = s[59];
      st = (|s[58:0]) | aln_q.sticky;
      ek = aln_q.elsb + 12'sd60;
    end else begin
      k  = s[111:59];
      g  = s[58];
      st = (|s[57:0]) | aln_q.sticky;
      ek = aln_q.elsb + 12'sd59;
    end
    kr = {1'b0, k} + 54'(g & (st | k[0]));
    sum_d.spec = aln_q.spec;
    if (kr[53]) begin
      sum_d.m = kr[53:1];
      sum_d.e = ek + 12'sd1;
    end else begin
      sum_d.m = kr[52:0];
      sum_d.e = ek;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aln_q <= aln_d;
      sum_q <= sum_d;
    end
  end

  assign vld_o = vld2_q;
  assign sum_o = sum_q;

endmodule
`default_nettype wire

### hw/rtl/hyp_sqrt.sv
`default_nettype none
module hyp_sqrt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           vld_i,
  input  wire hyp_pkg::sum_t  sum_i,
  output logic                vld_o,
  output hyp_pkg::root_t      root_o
);
  import hyp_pkg::*;

  root_t              init;
  root_t              stg_in [SQ_STAGES];
  root_t              stg_d  [SQ_STAGES];
  root_t              stg_q  [SQ_STAGES];
  logic [SQ_STAGES-1:0] vld_q;
  logic signed [11:0] e0;

  // radicand with leading one at bit 61 or 62, exponent made even
  always_comb begin
    e0 = sum_i.e - 12'sd9;
    init.spec = sum_i.spec;
    init.res  = '0;
    init.odd  = e0[0];
    if (e0[0]) begin
      init.rem = {sum_i.m, 10'd0};
      init.h   = (e0 - 12'sd1) >>> 1;
    end else begin
      init.rem = {1'b0, sum_i.m, 9'd0};
      init.h   = e0 >>> 1;
    end
  end

  assign stg_in[0] = init;

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign stg_in[g] = stg_q[g-1];
    end

    always_comb begin
      root_t       r;
      logic [63:0] bitv;
      logic [63:0] trial;
      r = stg_in[g];
      for (int i = 0; i < SQ_STEPS; i++) begin
        bitv  = 64'd1 << (SQ_TOP - 2 * (SQ_STEPS * g + i));
        trial = r.res + bitv;
        if ({1'b0, r.rem} >= trial) begin
          r.rem = r.rem - trial[62:0];
          r.res = (r.res >> 1) + bitv;
        end else begin
          r.res = r.res >> 1;
        end
      end
      stg_d[g] = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= (g == 0) ? vld_i : vld_q[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[g] <= stg_d[g];
      end
    end
  end

  assign vld_o  = vld_q[SQ_STAGES-1];
  assign root_o = stg_q[SQ_STAGES-1];

endmodule
`default_nettype wire

### hw/rtl/hyp_pack.sv
`default_nettype none
module hyp_pack (
  input  wire hyp_pkg::root_t  root_i,
  output logic [31:0]          bits_o
);
  import hyp_pkg::*;

  logic [31:0]        r, q, mask;
  logic signed [11:0] p, sv;
  logic               normal, exact, rbit, sticky;
  logic [5:0]         sh;
  logic [32:0]        qr, o;
  logic [7:0]         pe;

  always_comb begin
    r      = root_i.res[31:0];
    exact  = (root_i.rem == '0);
    // root has 31 bits, or 32 when the radicand was shifted for an odd exponent
    p      = 12'sd30 + $signed({11'd0, root_i.odd}) + root_i.h;
    normal = (p >= -12'sd126);
    sv     = -12'sd149 - root_i.h;
    if (normal) begin
      sh = root_i.odd ? 6'd8 : 6'd7;
    end else if (sv > 12'sd40) begin
      sh = 6'd40;
    end else begin
      sh = sv[5:0];
    end
    q      = r >> sh;
    rbit   = |((r >> (sh - 6'd1)) & 32'd1);
    mask   = (32'd1 << (sh - 6'd1)) - 32'd1;
    sticky = (|(r & mask)) | !exact;
    qr     = 33'(q) + 33'(rbit & (sticky | q[0]));
    pe     = 8'(p + 12'sd126);
    o      = normal ? (33'({pe, 23'd0}) + qr) : qr;
    if (root_i.spec.hit) begin
      bits_o = root_i.spec.bits;
    end else if ((normal && p > 12'sd127) || o >= 33'(INF_BITS)) begin
      bits_o = INF_BITS;
    end else begin
      bits_o = o[31:0];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/fp32_hypot_via_double_top.sv
`default_nettype none
// Single-precision hypotenuse, sqrt(x*x + y*y), computed through double.
// Input channel s_axis: one word carries both operands, x in tdata[31:0],
// y in tdata[63:32]. Output channel m_axis: tdata[31:0] is the result.
// Every input word gives exactly one output word, in order.
// Throughput: one word per cycle while the skid register is empty. A word
// passes through 21 register stages (2 unpack/square stages, 2 align/add
// stages, 16 root stages at two result bits each, one output register).
// Infinity on either side gives +inf, else a NaN operand (x first) comes
// back quieted, else the squares are summed and rounded to double, and the
// root of that sum is rounded once to single, nearest even.
// Reset clears all valid bits; no word is in flight afterwards.
// When m_axis stalls, a finished word waits in the output register and the
// next one goes to a skid register; only with both full does s_axis_tready
// drop, and the whole pipeline then holds until the output drains.
module fp32_hypot_via_double_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // x_bits [31:0], y_bits [63:32]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // hypot_bits [31:0]
);
  import hyp_pkg::*;

  logic        adv;
  logic        f_vld, a_vld, r_vld;
  sq_t         sq;
  sum_t        sum;
  root_t       root;
  logic [31:0] res_bits;
  logic        out_vld_q, skid_vld_q;
  logic [31:0] out_q, skid_q;
  logic        take, push;

  assign adv  = !skid_vld_q;
  assign take = out_vld_q && m_axis_tready;
  assign push = r_vld && adv;

  hyp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .vld_i    (s_axis_tvalid),
    .x_bits_i (s_axis_tdata[31:0]),
    .y_bits_i (s_axis_tdata[63:32]),
    .vld_o    (f_vld),
    .sq_o     (sq)
  );

  hyp_add u_add (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (f_vld),
    .sq_i   (sq),
    .vld_o  (a_vld),
    .sum_o  (sum)
  );

  hyp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (a_vld),
    .sum_i  (sum),
    .vld_o  (r_vld),
    .root_o (root)
  );

  hyp_pack u_pack (
    .root_i (root),
    .bits_o (res_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (!out_vld_q || take) begin
        if (skid_vld_q) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end else begin
          out_vld_q <= push;
        end
      end else if (push) begin
        skid_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || take) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res_bits;
      end
    end else if (push) begin
      skid_q <= res_bits;
    end
  end

  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_vld_q && !m_axis_tready) |=> skid_vld_q)
    else $error("word from pipeline not caught by skid register");

  a_hold_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(r_vld))
    else $error("pipeline moved while skid register full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && m_axis_tready) |=> !skid_vld_q)
    else $error("skid register not drained after output taken");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none
module tb_top;

  import hyp_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_LEN   = 160;
  localparam int DRAIN_CYC  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  logic [31:0] hypot_pending[$];
  int          fail_cnt = 0;
  int          idle_cnt = 0;
  int          stall_left;
  int          hold_left;
  int          hold_req;
  int          hold_seen;

  fp32_hypot_via_double_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // exact widening of |single| to double bits
  function automatic logic [63:0] widen_abs(input logic [31:0] b);
    logic [23:0] man;
    int          e;
    logic [10:0] de;
    man = {1'b0, b[22:0]};
    if (b[30:23] == 8'd0) begin
      if (man == 24'd0) return 64'd0;
      e = -126;
      while (man[23] == 1'b0) begin
        man = man << 1;
        e = e - 1;
      end
    end else begin
      man[23] = 1'b1;
      e = int'(b[30:23]) - 127;
    end
    de = 11'(e + 1023);
    return {1'b0, de, man[22:0], 29'd0};
  endfunction

  // RNE of a positive double to single, with subnormals and overflow
  function automatic logic [31:0] round_to_single(input logic [63:0] d);
    longint unsigned sig, q, out;
    int              e, shift;
    logic            rb, sticky;
    if (d[62:0] == 63'd0) return 32'd0;
    if (d[62:52] == 11'd0) return 32'd0;
    sig = {11'd0, 1'b1, d[51:0]};
    e = int'(d[62:52]) - 1023;
    if (e > 127) return INF_BITS;
    shift = (e >= -126) ? 29 : 29 + (-126 - e);
    if (shift > 60) return 32'd0;
    q = sig >> shift;
    rb = sig[shift-1];
    sticky = (sig & ((64'd1 << (shift - 1)) - 1)) != 0;
    if (rb && (sticky || q[0])) q = q + 1;
    if (e >= -126) out = (longint'(e + 126) << 23) + q;
    else out = q;
    if (out >= INF_BITS) return INF_BITS;
    return out[31:0];
  endfunction

  function automatic logic [31:0] hypot_of(input logic [31:0] xb, input logic [31:0] yb);
    logic [31:0] xa, ya;
    real         dx, dy, s;
    xa = xb & ABS_MASK;
    ya = yb & ABS_MASK;
    if (xa == INF_BITS || ya == INF_BITS) return INF_BITS;
    if (xa > INF_BITS) return xb | QUIET_BIT;
    if (ya > INF_BITS) return yb | QUIET_BIT;
    dx = $bitstoreal(widen_abs(xb));
    dy = $bitstoreal(widen_abs(yb));
    s = dx * dx + dy * dy;
    if (s == 0.0) return 32'd0;
    return round_to_single($realtobits($sqrt(s)));
  endfunction

  task automatic send_word(input logic [31:0] xb, input logic [31:0] yb, input int gap);
    s_axis_tdata  <= {yb, xb};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    hypot_pending.push_back(hypot_of(xb, yb));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    int          k;
    v = $urandom;
    k = $urandom_range(0, 99);
    if (k < 30) return v;
    if (k < 50) v[30:23] = 8'($urandom_range(100, 160));
    else if (k < 62) v[30:23] = 8'd0;
    else if (k < 70) v[30:23] = 8'($urandom_range(1, 20));
    else if (k < 78) v[30:23] = 8'($urandom_range(230, 254));
    else if (k < 83) v[30:0] = {8'hff, 23'd0};
    else if (k < 88) v[30:23] = 8'hff;
    else if (k < 92) v[30:0] = 31'd0;
    else v[30:23] = 8'($urandom_range(0, 254));
    return v;
  endfunction

  // receiver: random stalls, plus a long hold when a test asks for it
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
      hold_left     <= 0;
      hold_seen     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hypot_pending.size() == 0) begin
          $error("hypot_bits: no word expected, actual %h", m_axis_tdata);
          fail_cnt++;
        end else begin
          logic [31:0] want;
          want = hypot_pending.pop_front();
          if (want !== m_axis_tdata) begin
            $error("hypot_bits: expected %h, actual %h", want, m_axis_tdata);
            fail_cnt++;
          end
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen     <= hold_req;
        hold_left     <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        stall_left    <= pick_gap();
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [31:0] xs[20], ys[20];
    xs = '{32'h0000_0000, 32'h8000_0000, 32'h4040_0000, 32'hc040_0000, 32'h7f7f_ffff,
           32'h7f7f_ffff, 32'h0000_0001, 32'h0000_0001, 32'h0080_0000, 32'h007f_ffff,
           32'h7f80_0000, 32'h7fc0_0001, 32'h7f80_0001, 32'h3f80_0000, 32'hffa0_0000,
           32'h7f7f_ffff, 32'h1f80_0000, 32'h3f80_0001, 32'h5f80_0000, 32'h0000_0003};
    ys = '{32'h8000_0000, 32'h0000_0000, 32'h4080_0000, 32'hc080_0000, 32'h0000_0000,
           32'h7f7f_ffff, 32'h0000_0001, 32'h0000_0000, 32'h0080_0000, 32'h807f_ffff,
           32'h7fa0_0000, 32'hff80_0000, 32'h3f80_0000, 32'h7f80_0005, 32'h7fc1_2345,
           32'h0000_0001, 32'h1f80_0000, 32'h0000_0001, 32'h5f00_0000, 32'h0000_0004};
    for (int i = 0; i < 20; i++) send_word(xs[i], ys[i], (i % 3 == 0) ? 1 : 0);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) send_word(pick_operand(), pick_operand(), pick_gap());
  endtask

  // long receiver hold while words keep coming, so the pipe fills and backs up
  task automatic test_backpressure();
    hold_req = hold_req + 1;
    for (int i = 0; i < 60; i++) send_word(pick_operand(), pick_operand(), 0);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(200);
    test_backpressure();
    test_random(150);
    s_axis_tvalid <= 1'b0;
    while (hypot_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

### fp32_hypot_via_double_top.f
hw/rtl/hyp_pkg.sv
hw/rtl/hyp_front.sv
hw/rtl/hyp_add.sv
hw/rtl/hyp_sqrt.sv
hw/rtl/hyp_pack.sv
hw/rtl/fp32_hypot_via_double_top.sv
tb/sv/tb_top.sv
